>>> src/json_string_unescape_utf8_macros.svh
// Assertion macros used by the port-level checker of the JSON string unescape block.
// The macros expect clock aclk and active-low synchronous reset aresetn in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define JSU_CHK_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

>>> src/jsu_pkg.sv
// Package of the JSON string unescape block: command type, UTF-8 encoder, constants.
// No dependencies; used by the front end, the queue, the back end and the top level.
`default_nettype none

package jsu_pkg;

    // Default depth of the command queue between front and back end.
    localparam int JSU_FIFO_DEPTH = 4;

    // Surrogate prefixes (top six bits of a 16-bit code unit).
    localparam logic [5:0] JSU_HIGH_SURR_PREFIX = 6'b110110;
    localparam logic [5:0] JSU_LOW_SURR_PREFIX  = 6'b110111;
    localparam logic [20:0] JSU_SUPPLEMENTARY_BASE = 21'h10000;

    // UTF-8 encoding of one code point: bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } jsu_utf8_t;

    // One command: up to four segments, emitted in the order A, D, B, Y.
    typedef struct packed {
        logic [3:0][7:0] a_bytes;   // UTF-8 of a pending or combined code point
        logic [2:0]      a_len;
        logic [2:0][7:0] d_bytes;   // raw hex digits passed through
        logic [1:0]      d_len;
        logic [2:0][7:0] b_bytes;   // UTF-8 of a BMP code point
        logic [1:0]      b_len;
        logic [7:0]      y_byte;    // one single byte or the terminator
        logic            y_en;
        logic            y_nob;     // the single byte is a bare terminator
        logic            last;      // final command of the string
    } jsu_cmd_t;

    function automatic jsu_utf8_t jsu_utf8(input logic [20:0] cp);
        jsu_utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.len = 3'd1;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.len = 3'd2;
        end else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.len = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.len = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/jsu_fifo.sv
// Command queue between the front end and the back end of the unescape block.
// Depends on jsu_pkg for the command type.
`default_nettype none

module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::JSU_FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire jsu_pkg::jsu_cmd_t din,
    input  wire logic             pop,
    output jsu_pkg::jsu_cmd_t     dout,
    output logic                  not_empty,
    output logic                  full
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

>>> src/jsu_front.sv
// Front end of the unescape block: accepts raw bytes, tracks the escape state
// and turns each item that produces output into one command. Depends on jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_byte,
    input  wire logic          s_last_byte,
    input  wire logic          room,
    output logic               push,
    output jsu_pkg::jsu_cmd_t  cmd
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_PEND,
        MODE_PEND_ESC,
        MODE_PEND_HEX
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    mode_t       mode_reg, mode_next;
    logic [11:0] acc_reg, acc_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic [9:0]  pend_reg, pend_next;
    logic [7:0]  digit_reg [3];

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] acc16;
    logic [15:0] pend_cp16;
    logic [20:0] comb_cp;
    logic [2:0][7:0] digits_new;
    logic        wr_digit;
    logic        is_bs, is_u;
    logic        a_pend, a_comb, b_en, y_en, y_nob;
    logic [1:0]  d_len;
    logic [7:0]  y_byte;
    logic [20:0] a_cp;
    jsu_utf8_t   enc_a, enc_b;
    logic        no_output;

    function automatic logic [7:0] short_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E:   r = 8'h0A;   // n
            8'h74:   r = 8'h09;   // t
            8'h72:   r = 8'h0D;   // r
            8'h62:   r = 8'h08;   // b
            8'h66:   r = 8'h0C;   // f
            default: r = c;
        endcase
        return r;
    endfunction

    assign s_ready   = room;
    assign accept    = s_valid && room;
    assign is_bs     = (s_in_byte == CH_BSLASH);
    assign is_u      = (s_in_byte == CH_U);
    assign acc16     = {acc_reg, hex_d};
    assign pend_cp16 = {JSU_HIGH_SURR_PREFIX, pend_reg};
    assign comb_cp   = JSU_SUPPLEMENTARY_BASE + {1'b0, pend_reg, acc16[9:0]};

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = s_in_byte[3:0];
        if (s_in_byte >= 8'h30 && s_in_byte <= 8'h39) begin
            hex_d = s_in_byte[3:0];
        end else if ((s_in_byte >= 8'h61 && s_in_byte <= 8'h66) ||
                     (s_in_byte >= 8'h41 && s_in_byte <= 8'h46)) begin
            hex_d = s_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            digits_new[i] = (dcnt_reg == 2'(i)) ? s_in_byte : digit_reg[i];
        end
    end

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        pend_next = pend_reg;
        wr_digit  = 1'b0;
        a_pend    = 1'b0;
        a_comb    = 1'b0;
        b_en      = 1'b0;
        d_len     = 2'd0;
        y_en      = 1'b0;
        y_nob     = 1'b0;
        y_byte    = s_in_byte;

        unique case (mode_reg)
            MODE_PLAIN: begin
                if (is_bs) begin
                    mode_next = MODE_ESC;
                end else begin
                    y_en = 1'b1;
                end
            end
            MODE_ESC, MODE_PEND_ESC: begin
                if (is_u) begin
                    mode_next = (mode_reg == MODE_ESC) ? MODE_HEX : MODE_PEND_HEX;
                    acc_next  = '0;
                    dcnt_next = '0;
                end else begin
                    // A pending high surrogate goes out first, then the short escape.
                    a_pend    = (mode_reg == MODE_PEND_ESC);
                    y_en      = 1'b1;
                    y_byte    = short_escape(s_in_byte);
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_PEND: begin
                if (is_bs) begin
                    mode_next = MODE_PEND_ESC;
                end else begin
                    a_pend    = 1'b1;
                    y_en      = 1'b1;
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_HEX, MODE_PEND_HEX: begin
                if (!hex_ok) begin
                    // Drop the escape, pass the digits, then treat this byte as fresh.
                    a_pend    = (mode_reg == MODE_PEND_HEX);
                    d_len     = dcnt_reg;
                    dcnt_next = '0;
                    if (is_bs) begin
                        mode_next = MODE_ESC;
                    end else begin
                        y_en      = 1'b1;
                        mode_next = MODE_PLAIN;
                    end
                end else if (dcnt_reg != 2'd3) begin
                    wr_digit  = 1'b1;
                    acc_next  = {acc_reg[7:0], hex_d};
                    dcnt_next = dcnt_reg + 2'd1;
                end else begin
                    dcnt_next = '0;
                    if (mode_reg == MODE_PEND_HEX &&
                        acc16[15:10] == JSU_LOW_SURR_PREFIX) begin
                        a_comb    = 1'b1;
                        mode_next = MODE_PLAIN;
                    end else begin
                        a_pend = (mode_reg == MODE_PEND_HEX);
                        if (acc16[15:10] == JSU_HIGH_SURR_PREFIX) begin
                            pend_next = acc16[9:0];
                            mode_next = MODE_PEND;
                            // At end of string a new high surrogate is flushed at once.
                            b_en      = s_last_byte;
                        end else begin
                            b_en      = 1'b1;
                            mode_next = MODE_PLAIN;
                        end
                    end
                end
            end
            default: begin
                mode_next = MODE_PLAIN;
            end
        endcase

        if (s_last_byte) begin
            // Flush whatever the string leaves open; a lone backslash is dropped.
            unique case (mode_next)
                MODE_HEX: begin
                    d_len = dcnt_next;
                end
                MODE_PEND_ESC: begin
                    a_pend = 1'b1;
                end
                MODE_PEND_HEX: begin
                    a_pend = 1'b1;
                    d_len  = dcnt_next;
                end
                default: begin
                end
            endcase
            mode_next = MODE_PLAIN;
            acc_next  = '0;
            dcnt_next = '0;
            pend_next = '0;
        end

        no_output = !a_pend && !a_comb && (d_len == 2'd0) && !b_en && !y_en;
        if (s_last_byte && no_output) begin
            y_en   = 1'b1;
            y_nob  = 1'b1;
            y_byte = 8'h00;
        end
    end

    assign a_cp  = a_comb ? comb_cp : {5'd0, pend_cp16};
    assign enc_a = jsu_utf8(a_cp);
    assign enc_b = jsu_utf8({5'd0, acc16});

    always_comb begin
        cmd.a_bytes = enc_a.bytes;
        cmd.a_len   = (a_pend || a_comb) ? enc_a.len : 3'd0;
        cmd.d_bytes = digits_new;
        cmd.d_len   = d_len;
        cmd.b_bytes = enc_b.bytes[2:0];
        cmd.b_len   = b_en ? enc_b.len[1:0] : 2'd0;
        cmd.y_byte  = y_byte;
        cmd.y_en    = y_en;
        cmd.y_nob   = y_nob;
        cmd.last    = s_last_byte;
    end

    assign push = accept && !(no_output && !s_last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            acc_reg  <= '0;
            dcnt_reg <= '0;
            pend_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            dcnt_reg <= dcnt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && wr_digit) begin
            digit_reg[dcnt_reg] <= s_in_byte;
        end
    end

endmodule

`default_nettype wire

>>> src/jsu_back.sv
// Back end of the unescape block: walks the segments of the head command and
// sends one byte per cycle through the output register unless stalled. Depends on jsu_pkg.
`default_nettype none

module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire jsu_pkg::jsu_cmd_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_no_byte,
    output logic               m_end_of_string
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        SEG_A,
        SEG_D,
        SEG_B,
        SEG_Y
    } seg_t;

    seg_t       seg_reg, seg_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       nob_reg, nob_next;
    logic       eos_reg, eos_next;

    logic [2:0] lens [4];
    seg_t       cur, nxt;
    logic       found_cur, found_nxt;
    logic       seg_end, entry_done, load;
    logic [7:0] cur_byte;

    always_comb begin
        lens[0] = head.a_len;
        lens[1] = {1'b0, head.d_len};
        lens[2] = {1'b0, head.b_len};
        lens[3] = {2'b00, head.y_en};
    end

    // First non-empty segment at or after the current one, and the one after it.
    always_comb begin
        cur       = SEG_Y;
        found_cur = 1'b0;
        for (int s = 0; s < 4; s++) begin
            if (!found_cur && 2'(s) >= seg_reg && lens[s] != 3'd0) begin
                cur       = seg_t'(2'(s));
                found_cur = 1'b1;
            end
        end
        nxt       = SEG_A;
        found_nxt = 1'b0;
        for (int s = 0; s < 4; s++) begin
            if (!found_nxt && 2'(s) > cur && lens[s] != 3'd0) begin
                nxt       = seg_t'(2'(s));
                found_nxt = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (cur)
            SEG_A:   cur_byte = head.a_bytes[idx_reg];
            SEG_D:   cur_byte = head.d_bytes[idx_reg];
            SEG_B:   cur_byte = head.b_bytes[idx_reg];
            SEG_Y:   cur_byte = head.y_byte;
            default: cur_byte = head.y_byte;
        endcase
    end

    assign seg_end    = (({1'b0, idx_reg} + 3'd1) == lens[cur]);
    assign entry_done = seg_end && !found_nxt;
    assign load       = head_valid && (!m_valid_reg || m_ready);
    assign pop        = load && entry_done;

    always_comb begin
        seg_next     = seg_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        nob_next     = nob_reg;
        eos_next     = eos_reg;
        if (load) begin
            m_valid_next = 1'b1;
            byte_next    = cur_byte;
            nob_next     = (cur == SEG_Y) && head.y_nob;
            eos_next     = entry_done && head.last;
            if (!seg_end) begin
                seg_next = cur;
                idx_next = idx_reg + 2'd1;
            end else if (found_nxt) begin
                seg_next = nxt;
                idx_next = '0;
            end else begin
                seg_next = SEG_A;
                idx_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg     <= SEG_A;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seg_reg     <= seg_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        byte_reg <= byte_next;
        nob_reg  <= nob_next;
        eos_reg  <= eos_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_no_byte       = nob_reg;
    assign m_end_of_string = eos_reg;

endmodule

`default_nettype wire

>>> src/json_string_unescape_utf8.sv
// Top level of the JSON string unescape block: front end, command queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
//  Channel  Ports                                      Direction  Item
//  input    s_valid s_ready s_in_byte s_last_byte      in         one raw string byte
//  result   m_valid m_ready m_out_byte m_no_byte       out        one decoded byte
//           m_end_of_string
//
// The front end classifies each byte in the cycle it is accepted and writes
// one command into the queue for each item that produces output. A command
// passes through the queue and then the output register before the first
// result of an item appears; the back end sends an item's results in order.
// An item is accepted whenever the queue has room; plain bytes sustain one
// item per cycle unless results stall, and the back end's one-byte-per-cycle
// output register sets the pace during multi-byte escapes unless stalled.
// Reset is synchronous and active low; it empties the queue and returns the
// decoder to plain text mode. A stalled result holds in the output register
// while the queue keeps accepting items until it is full.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int FIFO_DEPTH = jsu_pkg::JSU_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_no_byte,
    output logic             m_end_of_string
);
    import jsu_pkg::*;

    jsu_cmd_t front_cmd;
    jsu_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     head_valid;
    logic     queue_full;

    // Front end: escape state machine, one command per item that produces output.
    jsu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .room        (!queue_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    // The queue lets the front keep accepting bytes while a long escape drains.
    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din       (front_cmd),
        .pop       (pop),
        .dout      (head_cmd),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // Back end: serializes each command into result items.
    jsu_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head_cmd),
        .head_valid      (head_valid),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_no_byte       (m_no_byte),
        .m_end_of_string (m_end_of_string)
    );

endmodule

`default_nettype wire

>>> src/json_string_unescape_utf8_checker.sv
// Port-level checker for the JSON string unescape block, bound to the top level.
// Depends on json_string_unescape_utf8_macros.svh.
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_in_byte,
    input wire logic       s_last_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_no_byte,
    input wire logic       m_end_of_string
);

    // A stalled result item keeps its contents.
    `JSU_CHK_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_no_byte) && $stable(m_end_of_string), "result item changed while stalled")

    // A bare terminator always closes the string and carries a zero byte.
    `JSU_CHK_SAME(a_terminator_form, m_valid && m_no_byte, m_end_of_string && (m_out_byte == 8'h00), "terminator item malformed")

    // After reset nothing is pending and the input side is open.
    `JSU_CHK_RESET(a_reset_clean, !m_valid && s_ready, "block not clean after reset")

endmodule

bind json_string_unescape_utf8 json_string_unescape_utf8_checker u_checker (.*);

`default_nettype wire
